// File: rtl/core/nectx_pkg.sv
// Package for the NEC IR frame transmitter: types, register codes and reset values.
package nectx_pkg;

  localparam int unsigned FrameBitsDefault = 32;
  localparam int unsigned NumRegs          = 8;
  localparam int unsigned RegW             = 16;
  localparam int unsigned CfgIdxW          = 8;
  localparam int unsigned WordW            = 32;

  localparam logic [RegW-1:0] LeaderMarkRst  = 16'd9000;
  localparam logic [RegW-1:0] LeaderSpaceRst = 16'd4500;
  localparam logic [RegW-1:0] BitMarkRst     = 16'd560;
  localparam logic [RegW-1:0] OneSpaceRst    = 16'd1690;
  localparam logic [RegW-1:0] ZeroSpaceRst   = 16'd560;
  localparam logic [RegW-1:0] TrailerMarkRst = 16'd560;
  localparam logic [RegW-1:0] CarrierTopRst  = 16'd25;
  localparam logic [RegW-1:0] CarrierCmpRst  = 16'd13;

  typedef enum logic [2:0] {
    RegLeaderMark  = 3'd0,
    RegLeaderSpace = 3'd1,
    RegBitMark     = 3'd2,
    RegOneSpace    = 3'd3,
    RegZeroSpace   = 3'd4,
    RegTrailerMark = 3'd5,
    RegCarrierTop  = 3'd6,
    RegCarrierCmp  = 3'd7
  } nectx_reg_e;

  typedef enum logic {
    OpTick  = 1'b0,
    OpFrame = 1'b1
  } nectx_op_e;

  typedef enum logic [2:0] {
    PhIdle      = 3'd0,
    PhLeadMark  = 3'd1,
    PhLeadSpace = 3'd2,
    PhBitMark   = 3'd3,
    PhBitSpace  = 3'd4,
    PhTrailer   = 3'd5
  } nectx_phase_e;

  typedef struct packed {
    nectx_op_e  operation;
    logic [7:0] address_byte;
    logic [7:0] command_byte;
  } nectx_in_t;

  typedef struct packed {
    logic ir_pin;
    logic envelope;
    logic busy_res;
    logic rejected;
  } nectx_out_t;

  typedef struct packed {
    logic [RegW-1:0] leader_mark_ticks;
    logic [RegW-1:0] leader_space_ticks;
    logic [RegW-1:0] bit_mark_ticks;
    logic [RegW-1:0] one_space_ticks;
    logic [RegW-1:0] zero_space_ticks;
    logic [RegW-1:0] trailer_mark_ticks;
    logic [RegW-1:0] carrier_period_top;
    logic [RegW-1:0] carrier_compare;
  } nectx_cfg_t;

  // A programmed length of zero behaves as a single tick.
  function automatic logic [RegW-1:0] phase_len(input logic [RegW-1:0] v);
    phase_len = (v == '0) ? RegW'(1) : v;
  endfunction

endpackage

// File: rtl/core/nectx_regs.sv
// Configuration register file of the NEC IR frame transmitter.
module nectx_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [nectx_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [nectx_pkg::RegW-1:0]  cfg_data_i,
  output nectx_pkg::nectx_cfg_t       cfg_o
);
  import nectx_pkg::*;

  nectx_cfg_t cfg_q;
  logic       wr_en;
  nectx_reg_e wr_reg;

  assign wr_en  = cfg_valid_i && (cfg_index_i < CfgIdxW'(NumRegs));
  assign wr_reg = nectx_reg_e'(cfg_index_i[2:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_mark_ticks  <= LeaderMarkRst;
      cfg_q.leader_space_ticks <= LeaderSpaceRst;
      cfg_q.bit_mark_ticks     <= BitMarkRst;
      cfg_q.one_space_ticks    <= OneSpaceRst;
      cfg_q.zero_space_ticks   <= ZeroSpaceRst;
      cfg_q.trailer_mark_ticks <= TrailerMarkRst;
      cfg_q.carrier_period_top <= CarrierTopRst;
      cfg_q.carrier_compare    <= CarrierCmpRst;
    end else if (wr_en) begin
      unique case (wr_reg)
        RegLeaderMark:  cfg_q.leader_mark_ticks  <= cfg_data_i;
        RegLeaderSpace: cfg_q.leader_space_ticks <= cfg_data_i;
        RegBitMark:     cfg_q.bit_mark_ticks     <= cfg_data_i;
        RegOneSpace:    cfg_q.one_space_ticks    <= cfg_data_i;
        RegZeroSpace:   cfg_q.zero_space_ticks   <= cfg_data_i;
        RegTrailerMark: cfg_q.trailer_mark_ticks <= cfg_data_i;
        RegCarrierTop:  cfg_q.carrier_period_top <= cfg_data_i;
        RegCarrierCmp:  cfg_q.carrier_compare    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/nectx_seq.sv
// Phase sequencer and carrier counter; forms the result of each accepted beat.
module nectx_seq #(
  parameter int unsigned FrameBits = nectx_pkg::FrameBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  nectx_pkg::nectx_in_t  item_i,
  input  nectx_pkg::nectx_cfg_t cfg_i,
  output nectx_pkg::nectx_out_t res_o
);
  import nectx_pkg::*;

  localparam int unsigned BnW = $clog2(FrameBits);
  localparam logic [BnW-1:0] LastBit = BnW'(FrameBits - 1);

  nectx_phase_e     phase_q, phase_d;
  logic [RegW-1:0]  left_q, left_d;
  logic [BnW-1:0]   bit_q, bit_d;
  logic [WordW-1:0] frame_q, frame_d;
  logic [RegW-1:0]  carrier_q, carrier_d;

  logic         busy;
  logic         start;
  logic         tick;
  logic [6:0]   bit_ext;
  logic         cur_bit;
  logic         carrier_high;
  nectx_phase_e view_phase;

  assign busy    = (phase_q != PhIdle);
  assign start   = (item_i.operation == OpFrame) && !busy;
  assign tick    = (item_i.operation == OpTick);
  assign bit_ext = 7'(bit_q);
  // Data bits beyond the 32-bit word are sent as zeros.
  assign cur_bit = (bit_ext < 7'(WordW)) ? frame_q[bit_ext[4:0]] : 1'b0;
  assign carrier_high = (carrier_q < cfg_i.carrier_compare) ||
                        (carrier_q == cfg_i.carrier_period_top);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      left_q    <= '0;
      bit_q     <= '0;
      frame_q   <= '0;
      carrier_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      left_q    <= left_d;
      bit_q     <= bit_d;
      frame_q   <= frame_d;
      carrier_q <= carrier_d;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    bit_d     = bit_q;
    frame_d   = frame_q;
    carrier_d = carrier_q;
    if (start) begin
      frame_d = {~item_i.command_byte, item_i.command_byte,
                 ~item_i.address_byte, item_i.address_byte};
      bit_d   = '0;
      phase_d = PhLeadMark;
      left_d  = phase_len(cfg_i.leader_mark_ticks);
    end else if (tick) begin
      carrier_d = (carrier_q >= cfg_i.carrier_period_top) ? '0 : carrier_q + RegW'(1);
      if (left_q > RegW'(1)) begin
        left_d = left_q - RegW'(1);
      end else begin
        unique case (phase_q)
          PhLeadMark: begin
            phase_d = PhLeadSpace;
            left_d  = phase_len(cfg_i.leader_space_ticks);
          end
          PhLeadSpace: begin
            bit_d   = '0;
            phase_d = PhBitMark;
            left_d  = phase_len(cfg_i.bit_mark_ticks);
          end
          PhBitMark: begin
            phase_d = PhBitSpace;
            left_d  = cur_bit ? phase_len(cfg_i.one_space_ticks)
                              : phase_len(cfg_i.zero_space_ticks);
          end
          PhBitSpace: begin
            if (bit_q == LastBit) begin
              phase_d = PhTrailer;
              left_d  = phase_len(cfg_i.trailer_mark_ticks);
            end else begin
              bit_d   = bit_q + BnW'(1);
              phase_d = PhBitMark;
              left_d  = phase_len(cfg_i.bit_mark_ticks);
            end
          end
          default: begin
            phase_d = PhIdle;
            left_d  = '0;
          end
        endcase
      end
    end
  end

  // A tick reports the state before it; an accepted request reports the new frame.
  assign view_phase = start ? PhLeadMark : phase_q;

  always_comb begin
    res_o.envelope = (view_phase == PhLeadMark) || (view_phase == PhBitMark) ||
                     (view_phase == PhTrailer);
    res_o.ir_pin   = res_o.envelope && carrier_high;
    res_o.busy_res = (view_phase != PhIdle);
    res_o.rejected = (item_i.operation == OpFrame) && busy;
  end

endmodule

// File: rtl/core/nec_ir_frame_transmitter_core.sv
// Top level of the NEC IR frame transmitter: handshakes, result register, submodules.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   nectx_in_t   in_data_i
//   out      output     out_valid_o / out_ready_i nectx_out_t  out_data_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// For each accepted input beat the sequencer state updates and the result lands
// in the output register at the same edge, so one beat per cycle is sustained
// while results are taken. The input side stalls only while the output register
// holds an untaken result. Reset puts the sequencer idle and loads the default NEC
// timing; configuration writes are always taken.
module nec_ir_frame_transmitter_core #(
  parameter int unsigned FrameBits = nectx_pkg::FrameBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  nectx_pkg::nectx_in_t          in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output nectx_pkg::nectx_out_t         out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [nectx_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [nectx_pkg::RegW-1:0]    cfg_data_i
);
  import nectx_pkg::*;

  nectx_cfg_t cfg;
  nectx_out_t res;
  nectx_out_t out_q;
  logic       out_valid_q;
  logic       accept;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  nectx_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  nectx_seq #(
    .FrameBits (FrameBits)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .item_i (in_data_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the NEC IR frame transmitter core with its own timing predictor.
module tb_top;
  import nectx_pkg::*;

  localparam int unsigned FrameN     = FrameBitsDefault;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned BatchCount = 11;
  localparam int unsigned BatchLen   = 100;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  nectx_in_t          in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  nectx_out_t         out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [RegW-1:0]    cfg_data  = '0;

  nectx_in_t  beats_to_send[$];
  nectx_out_t expected_levels[$];

  // Predicted copy of the timing registers and the frame sequencer.
  logic [RegW-1:0]  timing [NumRegs];
  nectx_phase_e     sim_phase;
  logic [RegW-1:0]  sim_left;
  int unsigned      sim_bit;
  logic [WordW-1:0] sim_word;
  logic [RegW-1:0]  sim_carrier;

  bit          steady     = 1'b0;
  int unsigned tx_wait    = 0;
  int unsigned rx_wait    = 0;
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;

  always #1 clk_i = ~clk_i;

  nec_ir_frame_transmitter_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  function automatic int unsigned draw_wait();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic void load_phase(nectx_phase_e p);
    logic [RegW-1:0] len;
    len = '0;
    case (p)
      PhLeadMark:  len = timing[RegLeaderMark];
      PhLeadSpace: len = timing[RegLeaderSpace];
      PhBitMark:   len = timing[RegBitMark];
      PhBitSpace:  len = sim_word[sim_bit] ? timing[RegOneSpace] : timing[RegZeroSpace];
      PhTrailer:   len = timing[RegTrailerMark];
      default:     len = '0;
    endcase
    sim_phase = p;
    // A programmed length of zero still lasts one tick.
    if (p == PhIdle) sim_left = '0;
    else sim_left = (len == '0) ? RegW'(1) : len;
  endfunction

  function automatic nectx_out_t frame_levels(nectx_in_t beat);
    nectx_out_t lv;
    logic       busy;
    logic       mark;
    lv.rejected = 1'b0;
    busy = (sim_phase >= PhLeadMark) && (sim_phase <= PhTrailer);
    if (beat.operation == OpFrame) begin
      if (busy) begin
        lv.rejected = 1'b1;
      end else begin
        sim_word = {~beat.command_byte, beat.command_byte,
                    ~beat.address_byte, beat.address_byte};
        sim_bit = 0;
        load_phase(PhLeadMark);
      end
    end
    busy = (sim_phase >= PhLeadMark) && (sim_phase <= PhTrailer);
    mark = (sim_phase == PhLeadMark) || (sim_phase == PhBitMark) || (sim_phase == PhTrailer);
    lv.envelope = mark;
    lv.busy_res = busy;
    lv.ir_pin   = mark && ((sim_carrier < timing[RegCarrierCmp]) ||
                           (sim_carrier == timing[RegCarrierTop]));
    // Only a tick moves time; a frame request leaves the carrier where it is.
    if (beat.operation == OpTick) begin
      sim_carrier = (sim_carrier >= timing[RegCarrierTop]) ? '0 : sim_carrier + 1'b1;
      if (busy) begin
        if (sim_left != '0) sim_left--;
        if (sim_left == '0) begin
          case (sim_phase)
            PhLeadMark:  load_phase(PhLeadSpace);
            PhLeadSpace: begin
              sim_bit = 0;
              load_phase(PhBitMark);
            end
            PhBitMark:   load_phase(PhBitSpace);
            PhBitSpace: begin
              sim_bit++;
              if (sim_bit >= FrameN) load_phase(PhTrailer);
              else load_phase(PhBitMark);
            end
            default:     load_phase(PhIdle);
          endcase
        end
      end else begin
        sim_phase = PhIdle;
      end
    end
    return lv;
  endfunction

  function automatic void queue_beat(nectx_op_e op, logic [7:0] a, logic [7:0] c);
    beats_to_send.push_back(nectx_in_t'{operation: op, address_byte: a, command_byte: c});
  endfunction

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < NumRegs) timing[idx[2:0]] = val;
  endtask

  // Returns once every queued beat has been taken and every result checked.
  // Sampling at the falling edge sees the handshake signals settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (beats_to_send.size() != 0 || expected_levels.size() != 0 || in_valid);
  endtask

  task automatic program_timing(input int unsigned b);
    int unsigned     max_len;
    logic [RegW-1:0] top;
    logic [RegW-1:0] cmp;
    max_len = (b % 3 == 0) ? 1 : (b % 3 == 1) ? 3 : 6;
    for (int r = 0; r < 6; r++) cfg_write(CfgIdxW'(r), RegW'($urandom_range(0, max_len)));
    case ($urandom_range(0, 5))
      0:       top = 16'd1;
      1:       top = 16'hFFFF;
      default: top = RegW'($urandom_range(2, 40));
    endcase
    cmp = RegW'($urandom_range(0, top + 2));
    if (b == 1) begin
      top = 16'd1;
      cmp = 16'd0;
    end else if (b == 2) begin
      top = 16'hFFFF;
      cmp = 16'hFFFF;
    end
    cfg_write(CfgIdxW'(RegCarrierTop), top);
    cfg_write(CfgIdxW'(RegCarrierCmp), cmp);
    if ($urandom_range(0, 2) == 0)
      cfg_write(CfgIdxW'($urandom_range(NumRegs, 255)), RegW'($urandom));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) expected_levels.push_back(frame_levels(in_data));
      if (!in_valid || in_ready) begin
        if (tx_wait != 0) begin
          in_valid <= 1'b0;
          tx_wait--;
        end else if (beats_to_send.size() != 0) begin
          in_data  <= beats_to_send.pop_front();
          in_valid <= 1'b1;
          tx_wait = draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin : check_beat
        nectx_out_t want;
        if (expected_levels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result pin/env/busy/rej %b%b%b%b arrived with none expected",
                     out_data.ir_pin, out_data.envelope, out_data.busy_res, out_data.rejected);
        end else begin
          want = expected_levels.pop_front();
          if (out_data.ir_pin !== want.ir_pin || out_data.envelope !== want.envelope ||
              out_data.busy_res !== want.busy_res || out_data.rejected !== want.rejected) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: pin/env/busy/rej expected %b%b%b%b got %b%b%b%b",
                       want.ir_pin, want.envelope, want.busy_res, want.rejected,
                       out_data.ir_pin, out_data.envelope, out_data.busy_res,
                       out_data.rejected);
          end
        end
        rx_wait = draw_wait();
      end
      if (rx_wait != 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    timing[RegLeaderMark]  = LeaderMarkRst;
    timing[RegLeaderSpace] = LeaderSpaceRst;
    timing[RegBitMark]     = BitMarkRst;
    timing[RegOneSpace]    = OneSpaceRst;
    timing[RegZeroSpace]   = ZeroSpaceRst;
    timing[RegTrailerMark] = TrailerMarkRst;
    timing[RegCarrierTop]  = CarrierTopRst;
    timing[RegCarrierCmp]  = CarrierCmpRst;
    sim_phase   = PhIdle;
    sim_left    = '0;
    sim_bit     = 0;
    sim_word    = '0;
    sim_carrier = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Short leader mark so the default carrier can be seen during the mark.
    cfg_write(CfgIdxW'(RegLeaderMark), 16'd30);
    for (int i = 0; i < 3; i++) queue_beat(OpTick, 8'hFF, 8'h00);
    queue_beat(OpFrame, 8'h00, 8'hFF);
    for (int i = 0; i < 12; i++) queue_beat(OpTick, 8'h55, 8'hAA);
    queue_beat(OpFrame, 8'hFF, 8'h00);
    for (int i = 0; i < 5; i++) queue_beat(OpTick, 8'hAA, 8'h55);
    wait_drained();

    // Zero lengths act as one tick; writes past the last register are dropped.
    cfg_write(CfgIdxW'(RegLeaderSpace), 16'd0);
    cfg_write(CfgIdxW'(RegBitMark), 16'd1);
    cfg_write(CfgIdxW'(RegOneSpace), 16'd2);
    cfg_write(CfgIdxW'(RegZeroSpace), 16'd0);
    cfg_write(CfgIdxW'(RegTrailerMark), 16'd3);
    cfg_write(CfgIdxW'(RegCarrierTop), 16'd1);
    cfg_write(CfgIdxW'(RegCarrierCmp), 16'd0);
    cfg_write(CfgIdxW'(NumRegs), 16'hFFFF);
    cfg_write({CfgIdxW{1'b1}}, 16'h0000);

    for (int unsigned b = 0; b < BatchCount; b++) begin
      if (b != 0) program_timing(b);
      steady = (b % 4 == 3);
      for (int unsigned i = 0; i < BatchLen; i++) begin
        if ($urandom_range(0, 49) == 0)
          queue_beat(OpFrame, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else
          queue_beat(OpTick, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      wait_drained();
    end

    // Longest phase lengths: only the start of such a frame fits in the run.
    steady = 1'b0;
    for (int r = 0; r < 6; r++) cfg_write(CfgIdxW'(r), 16'hFFFF);
    queue_beat(OpFrame, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    for (int i = 0; i < 40; i++)
      queue_beat(OpTick, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    queue_beat(OpFrame, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    for (int i = 0; i < 10; i++)
      queue_beat(OpTick, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
